[src/b2ssd_pkg.sv]
// Shared types and constants of the decimal seven-segment image builder.
// Used by binary_to_seven_segment_display_ram; depends on nothing else.
package b2ssd_pkg;

    localparam int VALUE_W       = 32;
    localparam int LIMIT_W       = 27;
    localparam int DIGIT_W       = 4;
    localparam int SEG_BITS      = 8;
    localparam int DISPLAY_BYTES = 16;
    localparam int ADDR_W        = 4;
    localparam int TABLE_W       = 80;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int OUT_DATA_W    = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 27'd100000000;
    localparam logic [63:0]        TABLE_LOW_RESET  = 64'h077D6D664F5B063F;
    localparam logic [15:0]        TABLE_HIGH_RESET = 16'h6F7F;

    // q = (v * RECIP) >> RECIP_SHIFT equals v / 10 for every v below 2^27.
    localparam logic [LIMIT_W-1:0] RECIP       = 27'd107374183;
    localparam int                 RECIP_SHIFT = 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALUE_LIMIT = 2'd0,
        CFG_TABLE_LOW   = 2'd1,
        CFG_TABLE_HIGH  = 2'd2
    } t_cfg_reg;

    typedef logic [SEG_BITS-1:0] t_seg;

    // Segment pattern of one decimal digit; the table holds digit n in byte n.
    function automatic t_seg pattern_of(input logic [TABLE_W-1:0] tbl,
                                        input logic [DIGIT_W-1:0] digit);
        t_seg pat;
        unique case (digit)
            4'd0:    pat = tbl[7:0];
            4'd1:    pat = tbl[15:8];
            4'd2:    pat = tbl[23:16];
            4'd3:    pat = tbl[31:24];
            4'd4:    pat = tbl[39:32];
            4'd5:    pat = tbl[47:40];
            4'd6:    pat = tbl[55:48];
            4'd7:    pat = tbl[63:56];
            4'd8:    pat = tbl[71:64];
            4'd9:    pat = tbl[79:72];
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

[src/binary_to_seven_segment_display_ram.sv]
// Decimal seven-segment image builder: limit check, one digit stage per decimal
// digit, segment lookup with transpose, and a sixteen-word output serializer.
// Depends on b2ssd_pkg.
//
// The first word of an image is presented once the value has passed stage 0,
// the digit stages, the segment register and the image register; the sixteen
// words then follow one per cycle while the output is ready. The serializer
// holds one image at a time, later values wait behind it, and a rejected value
// emits nothing. Values are taken every cycle while the digit pipeline has room.
// Reset (synchronous, active low) empties the pipeline and the serializer and
// restores the limit and the segment table to their default contents.
module binary_to_seven_segment_display_ram #(
    parameter int DIGITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream. tdata: value[31:0].
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [b2ssd_pkg::VALUE_W-1:0]         i_s_axis_tdata,
    // Output stream. tdata: reg_address[3:0], reg_data[11:4], zero[15:12].
    // tlast carries last_byte.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [b2ssd_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [b2ssd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [b2ssd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LW = b2ssd_pkg::LIMIT_W;
    localparam int DW = b2ssd_pkg::DIGIT_W;
    localparam int AW = b2ssd_pkg::ADDR_W;
    localparam int SB = b2ssd_pkg::SEG_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(b2ssd_pkg::DISPLAY_BYTES - 1);

    typedef logic [DIGITS-1:0][DW-1:0] t_digits;
    typedef logic [SB-1:0][SB-1:0]     t_image;

    // Configuration registers.
    logic [LW-1:0] r_value_limit;
    logic [63:0]   r_table_low;
    logic [15:0]   r_table_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= b2ssd_pkg::LIMIT_RESET;
            r_table_low   <= b2ssd_pkg::TABLE_LOW_RESET;
            r_table_high  <= b2ssd_pkg::TABLE_HIGH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                b2ssd_pkg::CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data[LW-1:0];
                b2ssd_pkg::CFG_TABLE_LOW:   r_table_low   <= i_cfg_data;
                b2ssd_pkg::CFG_TABLE_HIGH:  r_table_high  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers. Stage 0 holds the checked value; digit stage k
    // produces digit k and hands the quotient on through r_rem[k + 1].
    logic          r_v0;
    logic [LW-1:0] r_rem [DIGITS];
    t_digits       r_dig [DIGITS];
    logic          r_dv  [DIGITS];
    t_image        r_seg;
    logic          r_seg_v;
    t_image        r_img;
    logic          r_busy;
    logic [AW-1:0] r_addr;

    logic          w_room_d [DIGITS];
    logic          w_room0;
    logic          w_room_img;
    logic          w_load;
    logic          w_last_hs;
    logic          w_accept;

    assign w_last_hs  = r_busy && i_m_axis_tready && (r_addr == LAST_ADDR);
    assign w_load     = !r_busy || w_last_hs;
    assign w_room_img = !r_seg_v || w_load;
    assign w_room0    = !r_v0 || w_room_d[0];
    assign w_accept   = i_s_axis_tvalid && w_room0;

    assign o_s_axis_tready = w_room0;

    // Stage 0: limit check. Accepted values are below the 27-bit limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_room0) begin
            r_v0 <= i_s_axis_tvalid
                    && (i_s_axis_tdata < b2ssd_pkg::VALUE_W'(r_value_limit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rem[0] <= i_s_axis_tdata[LW-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIGITS; k++) begin : g_digit
            logic [2*LW-1:0] w_prod;
            logic [LW-1:0]   w_quo;
            logic [LW-1:0]   w_diff;
            logic            w_src_v;
            t_digits         n_dig;

            // Divide by ten through the reciprocal; the remainder is the digit.
            assign w_prod = (2*LW)'(r_rem[k]) * (2*LW)'(b2ssd_pkg::RECIP);
            assign w_quo  = LW'(w_prod[2*LW-1:b2ssd_pkg::RECIP_SHIFT]);
            assign w_diff = r_rem[k] - ((w_quo << 3) + (w_quo << 1));

            if (k == 0) begin : g_first
                assign w_src_v = r_v0;
                always_comb begin
                    n_dig    = '0;
                    n_dig[k] = w_diff[DW-1:0];
                end
            end else begin : g_next
                assign w_src_v = r_dv[k-1];
                always_comb begin
                    n_dig    = r_dig[k-1];
                    n_dig[k] = w_diff[DW-1:0];
                end
            end

            if (k == DIGITS - 1) begin : g_room_last
                assign w_room_d[k] = !r_dv[k] || w_room_img;
            end else begin : g_room_mid
                assign w_room_d[k] = !r_dv[k] || w_room_d[k+1];
                always_ff @(posedge i_clk) begin
                    if (w_room_d[k]) begin
                        r_rem[k+1] <= w_quo;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k] <= 1'b0;
                end else if (w_room_d[k]) begin
                    r_dv[k] <= w_src_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_room_d[k]) begin
                    r_dig[k] <= n_dig;
                end
            end
        end
    endgenerate

    // Segment lookup and transpose: bit b of digit d goes to bit d of row b.
    t_image n_seg;
    always_comb begin
        b2ssd_pkg::t_seg pat;
        n_seg = '0;
        for (int d = 0; d < DIGITS; d++) begin
            pat = b2ssd_pkg::pattern_of({r_table_high, r_table_low}, r_dig[DIGITS-1][d]);
            for (int b = 0; b < SB; b++) begin
                n_seg[b][d] = pat[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_v <= 1'b0;
        end else if (w_room_img) begin
            r_seg_v <= r_dv[DIGITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_room_img) begin
            r_seg <= n_seg;
        end
    end

    // Output serializer: sixteen words per image, even words carry a row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_addr <= '0;
        end else if (w_load) begin
            r_busy <= r_seg_v;
            r_addr <= '0;
        end else if (i_m_axis_tready) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_img <= r_seg;
        end
    end

    logic [SB-1:0] w_data;
    assign w_data = r_addr[0] ? '0 : r_img[r_addr[AW-1:1]];

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tdata  = {(b2ssd_pkg::OUT_DATA_W - SB - AW)'(0), w_data, r_addr};
    assign o_m_axis_tlast  = r_addr == LAST_ADDR;

    // An image, once started, goes out without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("output image interrupted");

    // An image that starts after an idle output begins at address zero.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_m_axis_tdata[AW-1:0] == '0))
        else $error("image does not start at address zero");

    // Odd display addresses carry no segments.
    a_odd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[AW+SB-1:AW] == '0))
        else $error("odd display byte not zero");

endmodule

[verif/tb.sv]
// Self-checking bench for binary_to_seven_segment_display_ram: streams values in, rebuilds
// each sixteen-byte display image independently and compares every output word.
// Depends on b2ssd_pkg and the block itself.
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_W       = b2ssd_pkg::VALUE_W;
    localparam int LIMIT_W       = b2ssd_pkg::LIMIT_W;
    localparam int DIGIT_W       = b2ssd_pkg::DIGIT_W;
    localparam int SEG_BITS      = b2ssd_pkg::SEG_BITS;
    localparam int DISPLAY_BYTES = b2ssd_pkg::DISPLAY_BYTES;
    localparam int ADDR_W        = b2ssd_pkg::ADDR_W;
    localparam int TABLE_W       = b2ssd_pkg::TABLE_W;
    localparam int CFG_DATA_W    = b2ssd_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W   = b2ssd_pkg::CFG_INDEX_W;
    localparam int OUT_DATA_W    = b2ssd_pkg::OUT_DATA_W;

    localparam int DIGITS         = 8;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES  = 2 * (DIGITS + 3) + 8;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 35;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [LIMIT_W-1:0]     LIMIT_MAX = '1;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [SEG_BITS-1:0] data;
        logic                last;
    } t_disp_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VALUE_W-1:0]     s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_data;
    logic                   m_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the configuration registers.
    logic [LIMIT_W-1:0] limit_shadow = b2ssd_pkg::LIMIT_RESET;
    logic [63:0]        table_low_shadow = b2ssd_pkg::TABLE_LOW_RESET;
    logic [15:0]        table_high_shadow = b2ssd_pkg::TABLE_HIGH_RESET;

    logic [VALUE_W-1:0] values_q[$];
    t_disp_word         image_words_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int shown_count = 0;
    int rejected_count = 0;
    int words_checked = 0;
    int reg_writes = 0;
    int phase_count = 0;
    int cycle_count = 0;

    binary_to_seven_segment_display_ram #(
        .DIGITS(DIGITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #2ns i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH cycle %0d: %s got 0x%0h, expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Builds and queues the sixteen words of a value below the limit, else counts it as rejected.
    function automatic void predict_image(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0]  rest;
        logic [DIGIT_W-1:0]  dig;
        logic [SEG_BITS-1:0] pat;
        logic [TABLE_W-1:0]  seg_table;
        logic [SEG_BITS-1:0] img [DISPLAY_BYTES];
        t_disp_word          w;
        if (value >= VALUE_W'(limit_shadow)) begin
            rejected_count++;
            return;
        end
        seg_table = {table_high_shadow, table_low_shadow};
        rest = value;
        for (int a = 0; a < DISPLAY_BYTES; a++) img[a] = '0;
        for (int d = 0; d < DIGITS; d++) begin
            dig  = DIGIT_W'(rest % 10);
            rest = rest / 10;
            pat  = seg_table[dig*SEG_BITS +: SEG_BITS];
            // Segment b of digit d lands in bit d of even byte 2*b.
            for (int b = 0; b < SEG_BITS; b++)
                if (pat[b]) img[2*b][d] = 1'b1;
        end
        for (int a = 0; a < DISPLAY_BYTES; a++) begin
            w.addr = ADDR_W'(a);
            w.data = img[a];
            w.last = (a == DISPLAY_BYTES - 1);
            image_words_q.push_back(w);
        end
        shown_count++;
    endfunction

    // Value driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_image(s_data);
            if (!s_valid || s_ready) begin
                if (values_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= values_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Display word monitor.
    always @(posedge i_clk) begin : monitor
        t_disp_word want;
        if (i_rst_n && m_valid && m_ready) begin
            if (image_words_q.size() == 0) begin
                report_mismatch("word with no image pending", m_data, 0);
            end else begin
                want = image_words_q.pop_front();
                words_checked++;
                if (m_data[ADDR_W-1:0] != want.addr)
                    report_mismatch("reg_address", m_data[ADDR_W-1:0], want.addr);
                if (m_data[ADDR_W +: SEG_BITS] != want.data)
                    report_mismatch("reg_data", m_data[ADDR_W +: SEG_BITS], want.data);
                if (m_data[OUT_DATA_W-1:ADDR_W+SEG_BITS] != '0)
                    report_mismatch("tdata padding", m_data[OUT_DATA_W-1:ADDR_W+SEG_BITS], 0);
                if (m_last != want.last)
                    report_mismatch("last_byte", m_last, want.last);
            end
        end
        m_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            b2ssd_pkg::CFG_VALUE_LIMIT: limit_shadow = data[LIMIT_W-1:0];
            b2ssd_pkg::CFG_TABLE_LOW:   table_low_shadow = data;
            b2ssd_pkg::CFG_TABLE_HIGH:  table_high_shadow = data[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Upper bits of the word are random; only the low 27 bits should matter.
    task automatic set_limit(input logic [LIMIT_W-1:0] lim);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[LIMIT_W-1:0] = lim;
        write_reg(b2ssd_pkg::CFG_VALUE_LIMIT, word);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Rejected values emit nothing, so the pipeline gets extra cycles to empty.
    task automatic finish_phase();
        do @(posedge i_clk);
        while (values_q.size() != 0 || s_valid || image_words_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        phase_count++;
    endtask

    initial begin
        logic [LIMIT_W-1:0] new_limit;
        logic [VALUE_W-1:0] val;
        int r;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset contents: digit extremes, nines, and values at the default limit.
        set_idling(0);
        values_q = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd12345678, 32'd87654321,
                     32'd99999999, 32'd100000000, 32'hFFFF_FFFF, 32'd98765432};
        finish_phase();

        // A limit of zero rejects everything; the spare index must change nothing.
        set_limit('0);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        values_q = '{32'd0, 32'd5, 32'hFFFF_FFFF};
        finish_phase();

        // Largest limit shows values above one hundred million modulo that.
        write_reg(b2ssd_pkg::CFG_VALUE_LIMIT, '1);
        write_reg(b2ssd_pkg::CFG_TABLE_LOW, '0);
        write_reg(b2ssd_pkg::CFG_TABLE_HIGH, 16'hFFFF);
        values_q = '{32'd134217726, 32'd134217727, 32'd100000000, 32'd88889999,
                     32'd123456789, 32'd0};
        finish_phase();
        write_reg(b2ssd_pkg::CFG_TABLE_LOW, '1);
        write_reg(b2ssd_pkg::CFG_TABLE_HIGH, '0);
        values_q = '{32'd0, 32'd99999999};
        finish_phase();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       new_limit = LIMIT_W'(1);
                1:       new_limit = b2ssd_pkg::LIMIT_RESET;
                2:       new_limit = LIMIT_MAX;
                default: new_limit = LIMIT_W'($urandom_range(100000000, 1));
            endcase
            set_limit(new_limit);
            write_reg(b2ssd_pkg::CFG_TABLE_LOW, (ph == 3) ? 64'd0 : {$urandom, $urandom});
            write_reg(b2ssd_pkg::CFG_TABLE_HIGH, (ph == 4) ? 16'hFFFF : 16'($urandom));
            set_idling(ph);
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                r = $urandom_range(99);
                if (r < 75)
                    val = $urandom_range(VALUE_W'(limit_shadow) - 1, 0);
                else if (r < 85)
                    val = VALUE_W'(limit_shadow) - $urandom_range(1, 0);
                else
                    val = $urandom;
                values_q.push_back(val);
            end
            finish_phase();
        end

        if (image_words_q.size() != 0)
            report_mismatch("display words never produced", image_words_q.size(), 0);
        $display("Sent %0d values: %0d displayed, %0d rejected; %0d display words checked.",
                 shown_count + rejected_count, shown_count, rejected_count, words_checked);
        $display("%0d register writes over %0d phases, limits from zero to the 27-bit maximum.",
                 reg_writes, phase_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
